### hdl/hidl_pkg.sv
`default_nettype none

package hidl_pkg;

  // default section geometry
  localparam int unsigned DEF_SLOT_COUNT  = 55;
  localparam int unsigned DEF_POLY_COUNT  = 6;
  localparam int unsigned DEF_COEFF_COUNT = 256;

  // operand width of the shared comparator: covers 0..256
  localparam int unsigned CMP_W = 9;

  // comparator request: lt = (a < b)
  typedef struct packed {
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
  } cmp_req_t;

endpackage

`default_nettype wire

### hdl/hint_index_list_decoder_core.sv
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] hint_byte
// m_axis    out  tdata poly_number, word_number, hint_bits; tuser malformed; tlast last
//
// Load: one byte per valid cycle, SLOT_COUNT + POLY_COUNT beats per section.
// Decode: per polynomial a low and a high count check; per used slot a slot RAM
// read, an order check, a range check with bitmap read and a bitmap write; per
// unused slot a zero check. Emit: one bitmap word per cycle while the sink is ready,
// bitmap RAM read bound. Reset needs no clearing pass; valid bits clear as a load ends.
// s_axis_tready is high only while loading; the output register holds a beat
// until taken, and loading of the next section may start meanwhile.
module hint_index_list_decoder_core #(
  parameter int unsigned SLOT_COUNT  = hidl_pkg::DEF_SLOT_COUNT,
  parameter int unsigned POLY_COUNT  = hidl_pkg::DEF_POLY_COUNT,
  parameter int unsigned COEFF_COUNT = hidl_pkg::DEF_COEFF_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] hint_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [71:0] m_axis_tdata_o,   // [2:0] poly_number, [4:3] word_number,
                                             // [68:5] hint_bits, [71:69] zero
  output      logic        m_axis_tuser_o,   // [0] malformed
  output      logic        m_axis_tlast_o
);

  localparam int unsigned SAW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PW       = (POLY_COUNT > 1) ? $clog2(POLY_COUNT) : 1;
  localparam int unsigned BAW      = PW + 2;
  localparam int unsigned BM_DEPTH = 1 << BAW;
  localparam int unsigned SECTION  = SLOT_COUNT + POLY_COUNT;
  localparam int unsigned BPW      = $clog2(SECTION);
  localparam int unsigned WPP      = (COEFF_COUNT + 63) / 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_P_LO,
    ST_P_HI,
    ST_S_ORDER,
    ST_S_RANGE,
    ST_S_WR,
    ST_T_CHK,
    ST_EMIT,
    ST_BAD
  } state_e;

  state_e                state_q, state_d;
  logic [BPW-1:0]        bpos_q, bpos_d;
  logic [PW-1:0]         p_q, p_d;
  logic [1:0]            w_q, w_d;
  logic [7:0]            s_q, s_d;
  logic [7:0]            last_q, last_d;
  logic                  first_q, first_d;
  logic [BM_DEPTH-1:0]   bvalid_q, bvalid_d;
  logic [BAW-1:0]        bm_raddr_q, bm_raddr_d;
  logic                  m_valid_q, m_valid_d;
  logic [2:0]            m_poly_q, m_poly_d;
  logic [1:0]            m_word_q, m_word_d;
  logic [63:0]           m_bits_q, m_bits_d;
  logic                  m_bad_q, m_bad_d;
  logic                  m_last_q, m_last_d;

  logic [7:0]            counts_q [POLY_COUNT];
  logic                  cnt_we;
  logic [BPW-1:0]        cnt_wpos;

  logic                  slot_we, slot_re;
  logic [SAW-1:0]        slot_raddr;
  logic [7:0]            slot_rdata;
  logic                  bm_we, bm_re;
  logic [BAW-1:0]        bm_raddr;
  logic [63:0]           bm_rdata, bm_wdata, bm_word;

  hidl_pkg::cmp_req_t    cmp_req;
  logic                  cmp_lt;

  logic                  in_beat, out_free;
  logic [7:0]            cnt, s_next;
  logic                  emit_last;
  logic [PW-1:0]         p_next;
  logic [1:0]            w_next;

  // index slot store
  hidl_ram #(
    .WIDTH (8),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (bpos_q[SAW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // hint bitmap store, {poly, word} addressed
  hidl_ram #(
    .WIDTH (64),
    .DEPTH (BM_DEPTH)
  ) u_bm_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_raddr_q),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  hidl_cmp u_cmp (
    .req_i (cmp_req),
    .lt_o  (cmp_lt)
  );

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign cnt      = counts_q[p_q];
  assign s_next   = s_q + 8'd1;
  // words never written this section read as zero
  assign bm_word  = bvalid_q[bm_raddr_q] ? bm_rdata : 64'd0;
  assign bm_wdata = bm_word | (64'd1 << last_q[5:0]);

  assign emit_last = (p_q == PW'(POLY_COUNT - 1)) && (w_q == 2'(WPP - 1));
  assign w_next    = (w_q == 2'(WPP - 1)) ? 2'd0 : (w_q + 2'd1);
  assign p_next    = (w_q == 2'(WPP - 1)) ? (p_q + PW'(1)) : p_q;

  assign cnt_wpos  = bpos_q - BPW'(SLOT_COUNT);
  assign cnt_we    = in_beat && (bpos_q >= BPW'(SLOT_COUNT));

  // sequencer
  always_comb begin
    state_d    = state_q;
    bpos_d     = bpos_q;
    p_d        = p_q;
    w_d        = w_q;
    s_d        = s_q;
    last_d     = last_q;
    first_d    = first_q;
    bvalid_d   = bvalid_q;
    bm_raddr_d = bm_raddr_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_poly_d   = m_poly_q;
    m_word_d   = m_word_q;
    m_bits_d   = m_bits_q;
    m_bad_d    = m_bad_q;
    m_last_d   = m_last_q;

    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_raddr = s_q[SAW-1:0];
    bm_we      = 1'b0;
    bm_re      = 1'b0;
    bm_raddr   = {p_q, w_q};
    cmp_req    = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          slot_we = (bpos_q < BPW'(SLOT_COUNT));
          if (bpos_q == BPW'(SECTION - 1)) begin
            bpos_d   = '0;
            bvalid_d = '0;
            p_d      = '0;
            s_d      = '0;
            state_d  = ST_P_LO;
          end else begin
            bpos_d = bpos_q + BPW'(1);
          end
        end
      end

      // count must not fall below the previous count
      ST_P_LO: begin
        cmp_req.a = {1'b0, cnt};
        cmp_req.b = {1'b0, s_q};
        state_d   = cmp_lt ? ST_BAD : ST_P_HI;
      end

      // count must not exceed the slot total
      ST_P_HI: begin
        cmp_req.a = hidl_pkg::CMP_W'(SLOT_COUNT);
        cmp_req.b = {1'b0, cnt};
        if (cmp_lt) begin
          state_d = ST_BAD;
        end else if (cnt == s_q) begin
          // empty polynomial: move on
          if (p_q == PW'(POLY_COUNT - 1)) begin
            if (cnt == 8'(SLOT_COUNT)) begin
              p_d      = '0;
              w_d      = '0;
              bm_re    = 1'b1;
              bm_raddr = '0;
              bm_raddr_d = '0;
              state_d  = ST_EMIT;
            end else begin
              slot_re = 1'b1;
              state_d = ST_T_CHK;
            end
          end else begin
            p_d     = p_q + PW'(1);
            state_d = ST_P_LO;
          end
        end else begin
          slot_re = 1'b1;
          first_d = 1'b1;
          state_d = ST_S_ORDER;
        end
      end

      // indices strictly increase within a polynomial
      ST_S_ORDER: begin
        cmp_req.a = {1'b0, slot_rdata};
        cmp_req.b = {1'b0, last_q} + hidl_pkg::CMP_W'(1);
        if (!first_q && cmp_lt) begin
          state_d = ST_BAD;
        end else begin
          last_d  = slot_rdata;
          state_d = ST_S_RANGE;
        end
      end

      // index below coefficient count, then fetch its bitmap word
      ST_S_RANGE: begin
        cmp_req.a = hidl_pkg::CMP_W'(COEFF_COUNT - 1);
        cmp_req.b = {1'b0, last_q};
        if (cmp_lt) begin
          state_d = ST_BAD;
        end else begin
          bm_re      = 1'b1;
          bm_raddr   = {p_q, last_q[7:6]};
          bm_raddr_d = {p_q, last_q[7:6]};
          state_d    = ST_S_WR;
        end
      end

      // set the bit, then next slot, next polynomial, the unused-slot check or emit
      ST_S_WR: begin
        bm_we                = 1'b1;
        bvalid_d[bm_raddr_q] = 1'b1;
        first_d              = 1'b0;
        s_d                  = s_next;
        if (s_next == cnt) begin
          if (p_q == PW'(POLY_COUNT - 1)) begin
            if (cnt == 8'(SLOT_COUNT)) begin
              p_d        = '0;
              w_d        = '0;
              bm_re      = 1'b1;
              bm_raddr   = '0;
              bm_raddr_d = '0;
              state_d    = ST_EMIT;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = s_next[SAW-1:0];
              state_d    = ST_T_CHK;
            end
          end else begin
            p_d     = p_q + PW'(1);
            state_d = ST_P_LO;
          end
        end else begin
          slot_re    = 1'b1;
          slot_raddr = s_next[SAW-1:0];
          state_d    = ST_S_ORDER;
        end
      end

      // unused slots must be zero
      ST_T_CHK: begin
        cmp_req.a = '0;
        cmp_req.b = {1'b0, slot_rdata};
        if (cmp_lt) begin
          state_d = ST_BAD;
        end else if (s_next == 8'(SLOT_COUNT)) begin
          p_d        = '0;
          w_d        = '0;
          bm_re      = 1'b1;
          bm_raddr   = '0;
          bm_raddr_d = '0;
          state_d    = ST_EMIT;
        end else begin
          s_d        = s_next;
          slot_re    = 1'b1;
          slot_raddr = s_next[SAW-1:0];
        end
      end

      // stream the bitmap out, one word per free output slot
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_poly_d  = 3'(p_q);
          m_word_d  = w_q;
          m_bits_d  = bm_word;
          m_bad_d   = 1'b0;
          m_last_d  = emit_last;
          if (emit_last) begin
            state_d = ST_LOAD;
          end else begin
            p_d        = p_next;
            w_d        = w_next;
            bm_re      = 1'b1;
            bm_raddr   = {p_next, w_next};
            bm_raddr_d = {p_next, w_next};
          end
        end
      end

      ST_BAD: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_poly_d  = '0;
          m_word_d  = '0;
          m_bits_d  = '0;
          m_bad_d   = 1'b1;
          m_last_d  = 1'b1;
          state_d   = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      bpos_q     <= '0;
      p_q        <= '0;
      w_q        <= '0;
      s_q        <= '0;
      last_q     <= '0;
      first_q    <= 1'b0;
      bvalid_q   <= '0;
      bm_raddr_q <= '0;
      m_valid_q  <= 1'b0;
      m_poly_q   <= '0;
      m_word_q   <= '0;
      m_bits_q   <= '0;
      m_bad_q    <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      bpos_q     <= bpos_d;
      p_q        <= p_d;
      w_q        <= w_d;
      s_q        <= s_d;
      last_q     <= last_d;
      first_q    <= first_d;
      bvalid_q   <= bvalid_d;
      bm_raddr_q <= bm_raddr_d;
      m_valid_q  <= m_valid_d;
      m_poly_q   <= m_poly_d;
      m_word_q   <= m_word_d;
      m_bits_q   <= m_bits_d;
      m_bad_q    <= m_bad_d;
      m_last_q   <= m_last_d;
    end
  end

  // per-polynomial cumulative counts
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      counts_q[cnt_wpos[PW-1:0]] <= s_axis_tdata_i;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_bits_q, m_word_q, m_poly_q};
  assign m_axis_tuser_o  = m_bad_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

### hdl/hidl_ram.sv
`default_nettype none

module hidl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/hidl_cmp.sv
`default_nettype none

module hidl_cmp (
  input  wire hidl_pkg::cmp_req_t req_i,
  output      logic               lt_o
);

  // shared magnitude comparator, used by every validation step
  assign lt_o = (req_i.a < req_i.b);

endmodule

`default_nettype wire

### tb/hint_bitmap_checker.sv
// Watches both channels of the hint decoder, rebuilds the hint bitmap from
// the accepted bytes and compares every output beat with the oldest
// predicted bitmap word.
module hint_bitmap_checker #(
  parameter int unsigned SLOT_COUNT  = hidl_pkg::DEF_SLOT_COUNT,
  parameter int unsigned POLY_COUNT  = hidl_pkg::DEF_POLY_COUNT,
  parameter int unsigned COEFF_COUNT = hidl_pkg::DEF_COEFF_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] hint_byte
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [71:0] m_axis_tdata_i,   // [2:0] poly_number, [4:3] word_number,
                                             // [68:5] hint_bits, [71:69] zero
  input  wire logic        m_axis_tuser_i,   // [0] malformed
  input  wire logic        m_axis_tlast_i,
  output      int          pending_o,
  output      int          errors_o
);

  localparam int unsigned WORDS_PER_POLY = (COEFF_COUNT + 63) / 64;
  localparam int unsigned SECTION_BYTES  = SLOT_COUNT + POLY_COUNT;
  localparam int          MAX_PRINT      = 60;

  typedef struct packed {
    logic [2:0]  poly;
    logic [1:0]  word;
    logic [63:0] bits;
    logic        malformed;
    logic        last;
  } hint_word_t;

  logic [7:0]  slot_mem   [SLOT_COUNT];
  logic [7:0]  count_mem  [POLY_COUNT];
  logic [63:0] bitmap_mem [POLY_COUNT*4];
  int unsigned load_pos;
  hint_word_t  bitmap_word_q [$];
  int          mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINT) $display("%0t hint_bitmap_checker: %s", $time, msg);
  endtask

  // Rebuild the bitmap from the stored slots and counts; ok low if malformed
  task automatic rebuild_bitmap(output bit ok);
    int unsigned lo, hi, idx;
    ok = 1'b1;
    lo = 0;
    for (int i = 0; i < POLY_COUNT*4; i++) bitmap_mem[i] = '0;
    for (int p = 0; p < POLY_COUNT && ok; p++) begin
      hi = count_mem[p];
      if (hi < lo || hi > SLOT_COUNT) begin
        ok = 1'b0;
      end else begin
        for (int s = lo; s < hi && ok; s++) begin
          idx = slot_mem[s];
          if (s > lo && idx <= slot_mem[s-1]) begin
            ok = 1'b0;
          end else if (idx >= COEFF_COUNT) begin
            ok = 1'b0;
          end else begin
            bitmap_mem[p*4 + idx/64][idx%64] = 1'b1;
          end
        end
        lo = hi;
      end
    end
    // slots past the final count must be zero
    if (ok) begin
      for (int s = lo; s < SLOT_COUNT; s++) if (slot_mem[s] != 8'h00) ok = 1'b0;
    end
  endtask

  // Store one accepted byte; the final byte of a section yields its words
  task automatic take_byte(input logic [7:0] b);
    bit ok;
    hint_word_t w;
    if (load_pos < SLOT_COUNT) slot_mem[load_pos] = b;
    else count_mem[load_pos - SLOT_COUNT] = b;
    load_pos++;
    if (load_pos == SECTION_BYTES) begin
      load_pos = 0;
      rebuild_bitmap(ok);
      if (!ok) begin
        w = '0;
        w.malformed = 1'b1;
        w.last = 1'b1;
        bitmap_word_q.push_back(w);
      end else begin
        for (int p = 0; p < POLY_COUNT; p++) begin
          for (int wd = 0; wd < WORDS_PER_POLY; wd++) begin
            w.poly = 3'(p);
            w.word = 2'(wd);
            w.bits = bitmap_mem[p*4 + wd];
            w.malformed = 1'b0;
            w.last = (p == POLY_COUNT - 1 && wd == WORDS_PER_POLY - 1);
            bitmap_word_q.push_back(w);
          end
        end
      end
    end
  endtask

  // Compare one output beat with the oldest predicted word
  task automatic check_word();
    hint_word_t want;
    if (bitmap_word_q.size() == 0) begin
      report_error($sformatf("beat with nothing pending: tdata=%h tuser=%b tlast=%b",
                             m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i));
      return;
    end
    want = bitmap_word_q.pop_front();
    if (m_axis_tdata_i[2:0] !== want.poly)
      report_error($sformatf("poly_number %0d, predicted %0d",
                             m_axis_tdata_i[2:0], want.poly));
    if (m_axis_tdata_i[4:3] !== want.word)
      report_error($sformatf("word_number %0d, predicted %0d (poly %0d)",
                             m_axis_tdata_i[4:3], want.word, want.poly));
    if (m_axis_tdata_i[68:5] !== want.bits)
      report_error($sformatf("hint_bits %h, predicted %h (poly %0d word %0d)",
                             m_axis_tdata_i[68:5], want.bits, want.poly, want.word));
    if (m_axis_tdata_i[71:69] !== 3'b000)
      report_error($sformatf("tdata padding %b not zero", m_axis_tdata_i[71:69]));
    if (m_axis_tuser_i !== want.malformed)
      report_error($sformatf("malformed %b, predicted %b", m_axis_tuser_i, want.malformed));
    if (m_axis_tlast_i !== want.last)
      report_error($sformatf("last %b, predicted %b (poly %0d word %0d)",
                             m_axis_tlast_i, want.last, want.poly, want.word));
  endtask

  // Output beats are checked before a new section is queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos = 0;
      bitmap_word_q.delete();
      for (int i = 0; i < SLOT_COUNT; i++) slot_mem[i] = 8'h00;
      for (int i = 0; i < POLY_COUNT; i++) count_mem[i] = 8'h00;
      for (int i = 0; i < POLY_COUNT*4; i++) bitmap_mem[i] = '0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_word();
      if (s_axis_tvalid_i && s_axis_tready_i) take_byte(s_axis_tdata_i);
      pending_o <= bitmap_word_q.size();
    end
  end

endmodule

### tb/hint_index_list_decoder_core_tb.sv
module hint_index_list_decoder_core_tb;

  localparam int unsigned SLOTS      = hidl_pkg::DEF_SLOT_COUNT;
  localparam int unsigned POLYS      = hidl_pkg::DEF_POLY_COUNT;
  localparam int unsigned COEFFS     = hidl_pkg::DEF_COEFF_COUNT;
  localparam int unsigned SECT_BYTES = SLOTS + POLYS;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          DRAIN_CYC  = 300;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_BUSY_LIGHT,
    SINK_BUSY_HEAVY,
    SINK_TOGGLE
  } sink_mode_e;

  // ways of spoiling an otherwise valid section
  typedef enum logic [1:0] {
    FAULT_COUNT_DROP,
    FAULT_COUNT_HIGH,
    FAULT_REPEAT,
    FAULT_STRAY
  } fault_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int          pending;
  int          mismatches;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  int          tick        = 0;
  int          mode_left   = 0;
  sink_mode_e  sink_mode   = SINK_FREE;
  logic [7:0]  sect [SECT_BYTES];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hint_index_list_decoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  hint_bitmap_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .pending_o       (pending),
    .errors_o        (mismatches)
  );

  // Sink stalls: a random mode drives tready until its random countdown runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      sink_mode <= SINK_FREE;
      mode_left <= 0;
      tick      <= 0;
    end else begin
      tick <= tick + 1;
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SINK_FREE:       m_tready <= 1'b1;
        SINK_BUSY_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
        SINK_BUSY_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
        default:         m_tready <= tick[2];
      endcase
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** hint_index_list_decoder_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte beat; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_section();
    for (int s = 0; s < SECT_BYTES; s++) send_byte(sect[s]);
  endtask

  // Hold off the source until every pending word has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Eight word-boundary indices per polynomial, seven unused slots
  task automatic build_edges();
    for (int s = 0; s < SECT_BYTES; s++) sect[s] = 8'h00;
    for (int p = 0; p < POLYS; p++) begin
      for (int e = 0; e < 8; e++) sect[p*8 + e] = 8'((e/2)*64 + (e%2)*63);
      sect[SLOTS + p] = 8'((p + 1) * 8);
    end
  endtask

  // Well-formed section with exactly 'total' hints spread over the polys
  task automatic build_valid(input int unsigned total);
    int unsigned cum, k, left, share, nset, v;
    logic [255:0] picked;
    cum = 0;
    share = 2 * total / POLYS + 2;
    for (int s = 0; s < SECT_BYTES; s++) sect[s] = 8'h00;
    for (int p = 0; p < POLYS; p++) begin
      left = total - cum;
      if (p == POLYS - 1) k = left;
      else k = $urandom_range(0, (left < share) ? left : share);
      picked = '0;
      nset = 0;
      while (nset < k) begin
        v = $urandom_range(0, COEFFS - 1);
        if (!picked[v]) begin
          picked[v] = 1'b1;
          nset++;
        end
      end
      for (int i = 0; i < COEFFS; i++) begin
        if (picked[i]) begin
          sect[cum] = 8'(i);
          cum++;
        end
      end
      sect[SLOTS + p] = 8'(cum);
    end
  endtask

  initial begin
    fault_e fault;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word edges in every polynomial, indices 0 and 255 included
    build_edges();
    send_section();
    wait_drained();

    // one malformed section, the flaw picked at random
    build_edges();
    fault = fault_e'($urandom_range(0, 3));
    unique case (fault)
      FAULT_COUNT_DROP: sect[SLOTS + 2] = sect[SLOTS + 1] - 8'd1;
      FAULT_COUNT_HIGH: sect[SLOTS] = 8'(SLOTS + 1);
      FAULT_REPEAT:     sect[1] = sect[0];
      FAULT_STRAY:      sect[SLOTS - 1] = 8'h01;
    endcase
    send_section();

    // random well-formed section, sometimes with every slot in use
    build_valid(($urandom_range(0, 1) == 0) ? SLOTS : $urandom_range(0, SLOTS));
    send_section();

    // Drain, then allow the decoder its latency before the verdict
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** hint_index_list_decoder_core: PASSED **");
    end else begin
      $display("** hint_index_list_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

### hint_index_list_decoder_core.f
hdl/hidl_pkg.sv
hdl/hidl_ram.sv
hdl/hidl_cmp.sv
hdl/hint_index_list_decoder_core.sv
tb/hint_bitmap_checker.sv
tb/hint_index_list_decoder_core_tb.sv
